>>> rtl/dasm_pkg.sv
// Package for the door access controller: shared types, codes and
// the LED and beeper helper functions. No dependencies.
package dasm_pkg;

   localparam int unsigned TIMER_W = 17;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'd0,
      ST_NEW        = 4'd1,
      ST_LOCKED     = 4'd2,
      ST_DEADLOCKED = 4'd3,
      ST_LOCKING    = 4'd4,
      ST_UNLOCKING  = 4'd5,
      ST_UNLOCKED   = 4'd6,
      ST_OPEN       = 4'd7,
      ST_NOTCLOSED  = 4'd8,
      ST_PROPPED    = 4'd9,
      ST_AJAR       = 4'd10,
      ST_FORCED     = 4'd11,
      ST_FAULT      = 4'd12,
      ST_TAMPER     = 4'd13,
      ST_BLIP       = 4'd14
   } door_state_type;

   typedef enum logic [3:0] {
      CMD_TICK       = 4'd0,
      CMD_OPEN       = 4'd1,
      CMD_PROP       = 4'd2,
      CMD_LOCK       = 4'd3,
      CMD_DEADLOCK   = 4'd4,
      CMD_UNDEADLOCK = 4'd5,
      CMD_UNLOCK     = 4'd6,
      CMD_ERR_BLIP   = 4'd7,
      CMD_OK_BLIP    = 4'd8
   } cmd_type;

   typedef enum logic [2:0] {
      REG_FORCE_DELAY  = 3'd0,
      REG_PROP_LIMIT   = 3'd1,
      REG_RELOCK_LIMIT = 3'd2,
      REG_UNLOCK_TIME  = 3'd3,
      REG_LOCK_TIME    = 3'd4,
      REG_QUIET_OPEN   = 3'd5,
      REG_FITTED_MASK  = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      BEEP_SILENT = 2'd0,
      BEEP_STEADY = 2'd1,
      BEEP_INTER  = 2'd2
   } beep_mode_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [3:0] command;
      logic [2:0] door_index;
      logic       door_sensor;
      logic       main_sense;
      logic       dead_sense;
      logic [2:0] tamper_flags;
      logic       half_phase;
      logic       sensor_found;
   } req_type;

   typedef struct packed {
      logic [2:0] door_number;
      logic [3:0] door_state;
      logic       state_changed;
      logic       main_release;
      logic       dead_release;
      logic       beep_out;
      logic [7:0] led_pattern;
      logic       led_update;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  force_delay;
      logic [15:0] prop_limit;
      logic [15:0] relock_limit;
      logic [15:0] unlock_time;
      logic [15:0] lock_time;
      logic        quiet_open;
      logic [3:0]  fitted_mask;
   } cfg_type;

   typedef struct packed {
      logic [3:0]                 door_mode;
      logic [15:0]                dwell_count;
      logic [7:0]                 force_count;
      logic                       prop_authorised;
      logic [1:0]                 beep_mode;
      logic [3:0]                 blip_count;
      logic                       main_engaged;
      logic signed [TIMER_W-1:0]  main_timer;
      logic                       main_drive;
      logic                       dead_engaged;
      logic signed [TIMER_W-1:0]  dead_timer;
      logic                       dead_drive;
      logic                       beep_level;
      logic [7:0]                 led_level;
   } door_rec_type;

   function automatic logic [7:0] led_for(
      input logic                      main_eng,
      input logic signed [TIMER_W-1:0] main_tmr,
      input logic                      dead_eng,
      input logic signed [TIMER_W-1:0] dead_tmr,
      input logic [3:0]                st
   );
      logic [7:0] led;
      led = 8'd0;
      if (st == ST_TAMPER) begin
         led = 8'hFF;
      end else begin
         led[0] = !main_eng;
         led[1] = main_eng;
         led[2] = (st != ST_OPEN && (main_tmr > 0 || dead_tmr > 0)) || st == ST_NOTCLOSED;
         led[3] = st == ST_FORCED || st == ST_FAULT;
         led[4] = st == ST_AJAR || st == ST_FAULT;
         led[5] = dead_eng;
      end
      return led;
   endfunction

   function automatic logic beep_for(input logic [1:0] mode, input logic half);
      return mode == BEEP_STEADY || (mode != BEEP_SILENT && half);
   endfunction

endpackage

>>> rtl/dasm_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on dasm_pkg.
interface dasm_req_if;
   logic               valid;
   logic               ready;
   dasm_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dasm_rsp_if;
   logic               valid;
   logic               ready;
   dasm_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dasm_store.sv
// Per-door record memory, registered read, valid bit per entry.
// Depends on dasm_pkg.
module dasm_store #(
   parameter int DOORS = 8,
   parameter int AW = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output dasm_pkg::door_rec_type rd_data,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  dasm_pkg::door_rec_type wr_data
);
   import dasm_pkg::*;

   door_rec_type mem [DOORS];
   door_rec_type rd_data_ff;
   logic [DOORS-1:0] valid_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;
endmodule

>>> rtl/dasm_update.sv
// Next-record logic for one door: tick classification, lock timers,
// commands, beeper and LED. Depends on dasm_pkg.
module dasm_update (
   input  dasm_pkg::door_rec_type cur,
   input  dasm_pkg::req_type      req,
   input  dasm_pkg::cfg_type      cfg,
   output dasm_pkg::door_rec_type nxt,
   output logic                   led_upd
);
   import dasm_pkg::*;

   door_rec_type r;
   logic [3:0] st;
   logic open;
   logic [2:0] tamper;
   logic signed [TIMER_W-1:0] lock_ld;
   logic signed [TIMER_W-1:0] unlock_ld;
   logic upd;

   assign lock_ld   = TIMER_W'({1'b0, cfg.lock_time});
   assign unlock_ld = TIMER_W'({1'b0, cfg.unlock_time});

   always_comb begin
      r      = cur;
      st     = cur.door_mode;
      open   = cfg.fitted_mask[0] & req.door_sensor;
      tamper = req.tamper_flags & cfg.fitted_mask[2:0];
      upd    = 1'b0;
      unique case (req.command)
         CMD_TICK: begin
            if (cur.door_mode != ST_IDLE) begin
               if (!open) begin
                  r.force_count = 8'd0;
               end else if (!r.dead_engaged && r.main_engaged && r.main_timer == 0
                            && r.force_count < cfg.force_delay) begin
                  r.force_count = r.force_count + 8'd1;
                  if (r.force_count < cfg.force_delay) begin
                     open = 1'b0;
                  end
               end
               if (st != ST_NEW) begin
                  if (tamper != 3'd0) begin
                     st = ST_TAMPER;
                  end else if (open) begin
                     if (r.dead_timer < 0) st = ST_FAULT;
                     else if (r.dead_engaged && r.dead_timer == 0) st = ST_FORCED;
                     else if (r.main_engaged && r.main_timer == 0 && cfg.fitted_mask[3])
                        st = ST_FORCED;
                     else if (st != ST_NOTCLOSED && st != ST_FORCED && st != ST_PROPPED)
                        st = ST_OPEN;
                     if ((st == ST_OPEN || st == ST_NOTCLOSED) && r.prop_authorised)
                        st = ST_PROPPED;
                  end else begin
                     r.prop_authorised = 1'b0;
                     if (r.dead_timer < 0) st = ST_FAULT;
                     else if (r.dead_engaged && r.dead_timer == 0) st = ST_DEADLOCKED;
                     else if (r.main_engaged && r.main_timer == 0) st = ST_LOCKED;
                     else if (r.main_engaged && r.main_timer < 0) st = ST_AJAR;
                     else if (r.main_engaged) st = ST_LOCKING;
                     else if (r.main_timer > 0) st = ST_UNLOCKING;
                     else st = ST_UNLOCKED;
                  end
               end
               if (open && !r.main_engaged) begin
                  r.main_engaged = 1'b1;
                  r.main_timer   = lock_ld;
                  r.main_drive   = 1'b0;
               end
               if (r.main_engaged && open) begin
                  r.main_timer = lock_ld;
               end else if (cfg.fitted_mask[1]
                            && (r.main_engaged ? !req.main_sense : req.main_sense)) begin
                  r.main_timer = '0;
               end else if (r.main_timer > 0) begin
                  r.main_timer = r.main_timer - TIMER_W'(1);
                  if (r.main_timer == 0 && cfg.fitted_mask[1]) r.main_timer = '1;
               end
               if (r.dead_engaged && open) begin
                  r.dead_timer = lock_ld;
               end else if (cfg.fitted_mask[2]
                            && (r.dead_engaged ? !req.dead_sense : req.dead_sense)) begin
                  r.dead_timer = '0;
               end else if (r.dead_timer > 0) begin
                  r.dead_timer = r.dead_timer - TIMER_W'(1);
                  if (r.dead_timer == 0 && cfg.fitted_mask[2]) r.dead_timer = '1;
               end
               if (st == cur.door_mode) begin
                  if (r.dwell_count != 16'hFFFF) r.dwell_count = r.dwell_count + 16'd1;
                  if (st == ST_NEW && (r.dwell_count > 16'd20 || !cfg.fitted_mask[0]
                                       || req.sensor_found)) begin
                     r.main_timer = TIMER_W'(10);
                     r.dead_timer = TIMER_W'(10);
                     st = open ? ST_UNLOCKING : ST_LOCKING;
                  end else if (st == ST_OPEN && cfg.prop_limit != 16'd0
                               && r.dwell_count >= cfg.prop_limit && cfg.fitted_mask[3]) begin
                     st = ST_NOTCLOSED;
                  end else if (st == ST_UNLOCKED && cfg.relock_limit != 16'd0
                               && r.dwell_count >= cfg.relock_limit) begin
                     if (!r.main_engaged) begin
                        r.main_engaged = 1'b1;
                        r.main_timer   = lock_ld;
                        r.main_drive   = 1'b0;
                     end
                     st = ST_LOCKING;
                  end
               end
               if (st != cur.door_mode) begin
                  r.door_mode   = st;
                  r.dwell_count = 16'd0;
                  if (!r.main_engaged && !cfg.quiet_open) r.beep_mode = BEEP_STEADY;
                  else if (st == ST_TAMPER || st == ST_FORCED || st == ST_NOTCLOSED
                           || st == ST_AJAR) r.beep_mode = BEEP_INTER;
                  else r.beep_mode = BEEP_SILENT;
               end
               if (r.blip_count == 4'd0) begin
                  r.beep_level = beep_for(r.beep_mode, req.half_phase);
                  r.led_level  = led_for(r.main_engaged, r.main_timer, r.dead_engaged,
                                         r.dead_timer, st);
                  upd = 1'b1;
               end else begin
                  r.blip_count = r.blip_count - 4'd1;
                  if (r.blip_count == 4'd3 || r.blip_count == 4'd9) begin
                     r.led_level  = led_for(r.main_engaged, r.main_timer, r.dead_engaged,
                                            r.dead_timer, ST_BLIP);
                     r.beep_level = 1'b1;
                     upd = 1'b1;
                  end else if (r.blip_count == 4'd0 || r.blip_count == 4'd6) begin
                     r.led_level  = led_for(r.main_engaged, r.main_timer, r.dead_engaged,
                                            r.dead_timer, st);
                     r.beep_level = (r.blip_count != 4'd0) ? 1'b0
                                    : beep_for(r.beep_mode, req.half_phase);
                     upd = 1'b1;
                  end
               end
            end
         end
         CMD_OPEN: begin
            if (r.main_engaged && !open) begin
               if (!cfg.quiet_open) begin
                  r.beep_mode  = BEEP_STEADY;
                  r.beep_level = 1'b1;
               end
               if (cfg.fitted_mask[3] && r.main_engaged) begin
                  r.main_engaged = 1'b0;
                  r.main_timer   = unlock_ld;
                  r.main_drive   = 1'b1;
               end
               if (r.dead_engaged) begin
                  r.dead_engaged = 1'b0;
                  r.dead_timer   = unlock_ld;
                  r.dead_drive   = 1'b1;
               end
            end
         end
         CMD_PROP: r.prop_authorised = 1'b1;
         CMD_LOCK: begin
            if (r.door_mode == ST_IDLE) r.door_mode = ST_NEW;
            if (!r.main_engaged) begin
               r.main_engaged = 1'b1;
               r.main_timer   = lock_ld;
               r.main_drive   = 1'b0;
            end
         end
         CMD_DEADLOCK: begin
            if (!r.main_engaged) begin
               r.main_engaged = 1'b1;
               r.main_timer   = lock_ld;
               r.main_drive   = 1'b0;
            end
            if (!r.dead_engaged) begin
               r.dead_engaged = 1'b1;
               r.dead_timer   = lock_ld;
               r.dead_drive   = 1'b0;
            end
         end
         CMD_UNDEADLOCK, CMD_UNLOCK: begin
            if (r.dead_engaged) begin
               r.dead_engaged = 1'b0;
               r.dead_timer   = unlock_ld;
               r.dead_drive   = 1'b1;
            end
         end
         CMD_ERR_BLIP: r.blip_count = 4'd5;
         CMD_OK_BLIP: r.blip_count = 4'd10;
         default: ;
      endcase
   end

   assign nxt     = r;
   assign led_upd = upd;
endmodule

>>> rtl/door_access_state_machine_core.sv
// Door access controller top level: request/result channels, register
// file and sequencer. Depends on dasm_pkg, dasm_if, dasm_store, dasm_update.
//
// Each request addresses one door record held in an on-chip memory and
// passes through the registered memory read, then the EXEC state in which
// the record is updated, written back and the result loaded; the sequencer
// takes one request at a time. A new request is taken while the previous
// result still waits, but the update cycle holds until the result register
// is free. Records read as zero after reset with no clearing pass. Doors at
// or above DOORS return a result with only door_number set.
module door_access_state_machine_core #(
   parameter int DOORS = 8
) (
   input  logic         clock,
   input  logic         reset,
   dasm_req_if.sink     req_chan,
   dasm_rsp_if.source   rsp_chan,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import dasm_pkg::*;

   localparam int AW = (DOORS > 1) ? $clog2(DOORS) : 1;

   fsm_type      state_ff, state_in;
   cfg_type      cfg_ff;
   req_type      req_ff;
   rsp_type      rsp_ff;
   logic         rsp_valid_ff;
   door_rec_type rd_rec, nxt_rec;
   logic         led_upd;
   logic         accept, done, in_range;
   rsp_type      rsp_in;

   assign req_chan.ready = (state_ff == FSM_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign in_range = 32'(req_ff.door_index) < DOORS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               done     = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_FORCE_DELAY:  cfg_ff.force_delay  <= csr_data[7:0];
            REG_PROP_LIMIT:   cfg_ff.prop_limit   <= csr_data;
            REG_RELOCK_LIMIT: cfg_ff.relock_limit <= csr_data;
            REG_UNLOCK_TIME:  cfg_ff.unlock_time  <= csr_data;
            REG_LOCK_TIME:    cfg_ff.lock_time    <= csr_data;
            REG_QUIET_OPEN:   cfg_ff.quiet_open   <= csr_data[0];
            REG_FITTED_MASK:  cfg_ff.fitted_mask  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_chan.data;
   end

   dasm_store #(.DOORS(DOORS), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (AW'(req_chan.data.door_index)),
      .rd_data (rd_rec),
      .wr_en   (done && in_range),
      .wr_addr (AW'(req_ff.door_index)),
      .wr_data (nxt_rec)
   );

   dasm_update u_update (
      .cur     (rd_rec),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .nxt     (nxt_rec),
      .led_upd (led_upd)
   );

   always_comb begin
      rsp_in = '0;
      rsp_in.door_number = req_ff.door_index;
      if (in_range) begin
         rsp_in.door_state    = nxt_rec.door_mode;
         rsp_in.state_changed = nxt_rec.door_mode != rd_rec.door_mode;
         rsp_in.main_release  = nxt_rec.main_drive;
         rsp_in.dead_release  = nxt_rec.dead_drive;
         rsp_in.beep_out      = nxt_rec.beep_level;
         rsp_in.led_pattern   = nxt_rec.led_level;
         rsp_in.led_update    = led_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;
endmodule
